/* src/fswg_pkg.sv */
// Shared constants, types and the sine table of the four-shape waveform generator.
`timescale 1ns / 1ps

package fswg_pkg;

  localparam int POINTS     = 128;
  localparam int PT_W       = 7;
  localparam int SAMPLE_W   = 12;
  localparam int DUTY_W     = 8;
  localparam int DIVIDEND_W = 24;
  localparam int DIV_CNT_W  = 5;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int MRAW_W     = 9;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'hfff;
  localparam logic [PT_W-1:0]     LAST_POINT = 7'(POINTS - 1);
  localparam logic [DUTY_W-1:0]   DUTY_FULL      = 8'd100;
  localparam logic [DUTY_W-1:0]   DUTY_NEAR_FULL = 8'd99;

  // floor(duty * 128 / 100) = (duty * DUTY_RECIP) >> DUTY_SHIFT for every 8-bit duty.
  localparam logic [15:0] DUTY_RECIP = 16'd41944;
  localparam int          DUTY_SHIFT = 15;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 5'(DIVIDEND_W - 1);

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_WAVE_KIND    = 3'd0;
  localparam logic [2:0] REG_AMPLITUDE    = 3'd1;
  localparam logic [2:0] REG_LOW_LEVEL    = 3'd2;
  localparam logic [2:0] REG_HIGH_LEVEL   = 3'd3;
  localparam logic [2:0] REG_DUTY_PERCENT = 3'd4;

  typedef enum logic [1:0] {
    WAVE_SINE = 2'd0,
    WAVE_RECT = 2'd1,
    WAVE_TRI  = 2'd2,
    WAVE_SAW  = 2'd3
  } wave_kind_t;

  localparam logic [SAMPLE_W-1:0] RST_AMPLITUDE  = 12'd4095;
  localparam logic [SAMPLE_W-1:0] RST_LOW_LEVEL  = 12'd0;
  localparam logic [SAMPLE_W-1:0] RST_HIGH_LEVEL = 12'd4095;
  localparam logic [DUTY_W-1:0]   RST_DUTY       = 8'd50;

  typedef struct packed {
    wave_kind_t            wave_kind;
    logic [SAMPLE_W-1:0]   amplitude;
    logic [SAMPLE_W-1:0]   low_level;
    logic [SAMPLE_W-1:0]   high_level;
    logic [DUTY_W-1:0]     duty_percent;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic prep;
    logic mul;
    logic cdiv;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_rect;
    logic is_tri;
    logic div_done;
    logic out_hold;
  } dp_status_t;

  localparam logic [SAMPLE_W-1:0] SINE_ROM [POINTS] = '{
    12'h800, 12'h864, 12'h8c9, 12'h92c, 12'h98f, 12'h9f1, 12'ha52, 12'hab2,
    12'hb0f, 12'hb6b, 12'hbc5, 12'hc1c, 12'hc71, 12'hcc3, 12'hd13, 12'hd5f,
    12'hda7, 12'hded, 12'he2e, 12'he6c, 12'hea6, 12'hedc, 12'hf0d, 12'hf3a,
    12'hf63, 12'hf87, 12'hfa7, 12'hfc2, 12'hfd8, 12'hfe9, 12'hff5, 12'hffd,
    12'hfff, 12'hffd, 12'hff5, 12'hfe9, 12'hfd8, 12'hfc2, 12'hfa7, 12'hf87,
    12'hf63, 12'hf3a, 12'hf0d, 12'hedc, 12'hea6, 12'he6c, 12'he2e, 12'hded,
    12'hda7, 12'hd5f, 12'hd13, 12'hcc3, 12'hc71, 12'hc1c, 12'hbc5, 12'hb6b,
    12'hb0f, 12'hab2, 12'ha52, 12'h9f1, 12'h98f, 12'h92c, 12'h8c9, 12'h864,
    12'h800, 12'h79c, 12'h737, 12'h6d4, 12'h671, 12'h60f, 12'h5ae, 12'h54e,
    12'h4f1, 12'h495, 12'h43b, 12'h3e4, 12'h38f, 12'h33d, 12'h2ed, 12'h2a1,
    12'h259, 12'h213, 12'h1d2, 12'h194, 12'h15a, 12'h124, 12'h0f3, 12'h0c6,
    12'h09d, 12'h079, 12'h059, 12'h03e, 12'h028, 12'h017, 12'h00b, 12'h003,
    12'h001, 12'h003, 12'h00b, 12'h017, 12'h028, 12'h03e, 12'h059, 12'h079,
    12'h09d, 12'h0c6, 12'h0f3, 12'h124, 12'h15a, 12'h194, 12'h1d2, 12'h213,
    12'h259, 12'h2a1, 12'h2ed, 12'h33d, 12'h38f, 12'h3e4, 12'h43b, 12'h495,
    12'h4f1, 12'h54e, 12'h5ae, 12'h60f, 12'h671, 12'h6d4, 12'h737, 12'h79c
  };

endpackage

/* src/fswg_if.sv */
// Valid/ready channel interfaces for sample ticks and generated samples.
`timescale 1ns / 1ps

interface fswg_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface fswg_result_if;
  logic                           valid;
  logic                           ready;
  logic [fswg_pkg::SAMPLE_W-1:0]  sample;
  logic [fswg_pkg::PT_W-1:0]      point_index;
  logic                           cycle_end;

  modport source (output valid, output sample, output point_index, output cycle_end,
                  input ready);
  modport sink (input valid, input sample, input point_index, input cycle_end,
                output ready);
endinterface

/* src/four_shape_waveform_sample_generator_core.sv */
// Top level of the four-shape waveform sample generator.
`timescale 1ns / 1ps
//
// Each beat on the tick channel is one DAC sample tick. The block answers it
// with one beat on the result channel: the 12-bit code of the current point of
// a 128-point cycle, the point's index, and a flag on the last point. The
// point then advances and wraps; a tick with restart set emits point 0.
// Shape (sine, rectangle, triangle, sawtooth), sine amplitude, low and high
// levels and duty are set through the APB-style register port, with the
// block idle.
// The restoring divider, used only for the triangle's point-dependent divisor,
// makes the triangle the slowest shape; rectangle skips the multiply and the
// division and is the fastest. One tick is in work at a time, so a new tick is
// taken at the earliest in the cycle after the previous result is loaded.
// The result sits in an output register, so a new tick is taken while it
// waits; when the receiver stalls, the next result is held back until the
// register empties and the tick channel stays blocked meanwhile.
// Reset puts the registers at their defaults (sine, full amplitude, levels
// 0 and 4095, duty 50) and the point counter at 0.
//

module four_shape_waveform_sample_generator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fswg_pkg::ADDR_W-1:0]   paddr,
  input  logic [fswg_pkg::DATA_W-1:0]   pwdata,
  output logic [fswg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  fswg_tick_if.sink                     tick,
  fswg_result_if.source                 result
);

  fswg_pkg::cfg_t        cfg;
  fswg_pkg::dp_cmd_t     cmd;
  fswg_pkg::dp_status_t  status;
  logic                  in_ready;

  assign pready     = 1'b1;
  assign tick.ready = in_ready;

  fswg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  fswg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tick.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  fswg_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .status          (status),
    .in_restart      (tick.restart),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .out_sample      (result.sample),
    .out_point_index (result.point_index),
    .out_cycle_end   (result.cycle_end)
  );

endmodule

/* src/fswg_regs.sv */
// APB-style configuration registers.
`timescale 1ns / 1ps

module fswg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fswg_pkg::ADDR_W-1:0]   paddr,
  input  logic [fswg_pkg::DATA_W-1:0]   pwdata,
  output logic [fswg_pkg::DATA_W-1:0]   prdata,
  output fswg_pkg::cfg_t                cfg
);

  logic       wr_en;
  logic [2:0] reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wave_kind    <= fswg_pkg::WAVE_SINE;
      cfg.amplitude    <= fswg_pkg::RST_AMPLITUDE;
      cfg.low_level    <= fswg_pkg::RST_LOW_LEVEL;
      cfg.high_level   <= fswg_pkg::RST_HIGH_LEVEL;
      cfg.duty_percent <= fswg_pkg::RST_DUTY;
    end else if (wr_en) begin
      case (reg_sel)
        fswg_pkg::REG_WAVE_KIND:    cfg.wave_kind    <= fswg_pkg::wave_kind_t'(pwdata[1:0]);
        fswg_pkg::REG_AMPLITUDE:    cfg.amplitude    <= pwdata[11:0];
        fswg_pkg::REG_LOW_LEVEL:    cfg.low_level    <= pwdata[11:0];
        fswg_pkg::REG_HIGH_LEVEL:   cfg.high_level   <= pwdata[11:0];
        fswg_pkg::REG_DUTY_PERCENT: cfg.duty_percent <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      fswg_pkg::REG_WAVE_KIND:    prdata = 32'(cfg.wave_kind);
      fswg_pkg::REG_AMPLITUDE:    prdata = 32'(cfg.amplitude);
      fswg_pkg::REG_LOW_LEVEL:    prdata = 32'(cfg.low_level);
      fswg_pkg::REG_HIGH_LEVEL:   prdata = 32'(cfg.high_level);
      fswg_pkg::REG_DUTY_PERCENT: prdata = 32'(cfg.duty_percent);
      default:                    prdata = '0;
    endcase
  end

endmodule

/* src/fswg_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module fswg_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [fswg_pkg::DIVIDEND_W-1:0]    dividend,
  input  logic [fswg_pkg::SAMPLE_W-1:0]      divisor,
  output logic                               done,
  output logic [fswg_pkg::DIVIDEND_W-1:0]    quotient
);

  logic                               busy;
  logic [fswg_pkg::DIV_CNT_W-1:0]     step;
  logic [fswg_pkg::SAMPLE_W-1:0]      rem;
  logic [fswg_pkg::SAMPLE_W-1:0]      den;
  logic [fswg_pkg::SAMPLE_W:0]        trial;
  logic [fswg_pkg::SAMPLE_W:0]        diff;
  logic                               fits;

  // The partial remainder always stays below the divisor, so 12 bits hold it.
  assign trial = {rem, quotient[fswg_pkg::DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = (trial >= {1'b0, den});
  assign done  = busy && (step == fswg_pkg::DIV_LAST_STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      den      <= divisor;
    end else if (busy) begin
      rem      <= fits ? diff[fswg_pkg::SAMPLE_W-1:0] : trial[fswg_pkg::SAMPLE_W-1:0];
      quotient <= {quotient[fswg_pkg::DIVIDEND_W-2:0], fits};
    end
  end

endmodule

/* src/fswg_dp.sv */
// Datapath: phase counter, operand setup, multiplier, divider and output register.
`timescale 1ns / 1ps

module fswg_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  fswg_pkg::cfg_t                    cfg,
  input  fswg_pkg::dp_cmd_t                 cmd,
  output fswg_pkg::dp_status_t              status,
  input  logic                              in_restart,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fswg_pkg::SAMPLE_W-1:0]     out_sample,
  output logic [fswg_pkg::PT_W-1:0]         out_point_index,
  output logic                              out_cycle_end
);

  logic [fswg_pkg::PT_W-1:0]        phase;
  logic [fswg_pkg::PT_W-1:0]        pt;
  logic [fswg_pkg::PT_W-1:0]        pt_sel;

  logic [fswg_pkg::DIVIDEND_W-1:0]  duty_prod;
  logic [fswg_pkg::MRAW_W-1:0]      m_raw;
  logic [fswg_pkg::PT_W-1:0]        m;
  logic [fswg_pkg::PT_W:0]          fall_den;

  logic signed [fswg_pkg::SAMPLE_W:0] span;
  logic [fswg_pkg::SAMPLE_W-1:0]    span_mag;
  logic                             rising;
  logic                             rect_high;
  logic [fswg_pkg::PT_W-1:0]        k_sel;
  logic [fswg_pkg::SAMPLE_W-1:0]    den_sel;
  logic [fswg_pkg::SAMPLE_W-1:0]    base_sel;
  logic                             minus_sel;

  logic [fswg_pkg::SAMPLE_W-1:0]    op_a;
  logic [fswg_pkg::SAMPLE_W-1:0]    op_b;
  logic [fswg_pkg::SAMPLE_W-1:0]    den;
  logic [fswg_pkg::SAMPLE_W-1:0]    base;
  logic                             minus;
  logic [fswg_pkg::SAMPLE_W-1:0]    rect_val;

  logic [fswg_pkg::DIVIDEND_W-1:0]  product;
  logic [fswg_pkg::DIVIDEND_W-1:0]  quotient;
  logic                             div_done;
  logic                             is_tri;

  logic [fswg_pkg::DIVIDEND_W-1:0]  prod_q;
  logic [fswg_pkg::SAMPLE_W-1:0]    sine_q0;
  logic [fswg_pkg::SAMPLE_W:0]      sine_r0;
  logic [fswg_pkg::SAMPLE_W-1:0]    sine_q;
  logic [fswg_pkg::SAMPLE_W-1:0]    saw_q0;
  logic [fswg_pkg::SAMPLE_W:0]      saw_r0;
  logic [fswg_pkg::SAMPLE_W-fswg_pkg::PT_W:0] saw_q1;
  logic [fswg_pkg::PT_W:0]          saw_r1;
  logic [fswg_pkg::SAMPLE_W-1:0]    saw_q;
  logic [fswg_pkg::SAMPLE_W-1:0]    const_q;
  logic [fswg_pkg::SAMPLE_W-1:0]    cq;
  logic [fswg_pkg::SAMPLE_W-1:0]    q_sel;

  logic signed [fswg_pkg::SAMPLE_W+2:0] base_s;
  logic signed [fswg_pkg::SAMPLE_W+2:0] q_s;
  logic signed [fswg_pkg::SAMPLE_W+2:0] sum;
  logic [fswg_pkg::SAMPLE_W-1:0]    shaped;
  logic [fswg_pkg::SAMPLE_W-1:0]    final_sample;

  assign pt_sel = in_restart ? '0 : phase;
  assign is_tri = (cfg.wave_kind == fswg_pkg::WAVE_TRI);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (cmd.accept) begin
      phase <= pt_sel + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pt <= pt_sel;
    end
  end

  // Rise share of the cycle, kept current with the duty register.
  assign duty_prod = fswg_pkg::DIVIDEND_W'(cfg.duty_percent)
                   * fswg_pkg::DIVIDEND_W'(fswg_pkg::DUTY_RECIP);

  always_ff @(posedge clk) begin
    m_raw <= duty_prod[fswg_pkg::DUTY_SHIFT +: fswg_pkg::MRAW_W];
  end

  always_comb begin
    if (m_raw == '0) begin
      m = 7'd1;
    end else if (m_raw > fswg_pkg::MRAW_W'(fswg_pkg::LAST_POINT)) begin
      m = fswg_pkg::LAST_POINT;
    end else begin
      m = m_raw[fswg_pkg::PT_W-1:0];
    end
  end

  assign fall_den = 8'(fswg_pkg::POINTS) - {1'b0, m};
  assign span     = $signed({1'b0, cfg.high_level}) - $signed({1'b0, cfg.low_level});
  assign span_mag = span[fswg_pkg::SAMPLE_W] ? fswg_pkg::SAMPLE_W'(-span)
                                             : span[fswg_pkg::SAMPLE_W-1:0];
  assign rising   = (pt < m);

  always_comb begin
    if (cfg.duty_percent >= fswg_pkg::DUTY_FULL) begin
      rect_high = 1'b1;
    end else if (cfg.duty_percent == '0) begin
      rect_high = 1'b0;
    end else if (cfg.duty_percent == fswg_pkg::DUTY_NEAR_FULL) begin
      rect_high = (pt != '0);
    end else begin
      rect_high = ({2'b00, pt} < m_raw);
    end
  end

  always_comb begin
    k_sel     = pt;
    den_sel   = 12'(fswg_pkg::LAST_POINT);
    base_sel  = cfg.low_level;
    minus_sel = span[fswg_pkg::SAMPLE_W];
    case (cfg.wave_kind)
      fswg_pkg::WAVE_SINE: begin
        den_sel   = fswg_pkg::FULL_SCALE;
        base_sel  = '0;
        minus_sel = 1'b0;
      end
      fswg_pkg::WAVE_TRI: begin
        if (rising) begin
          den_sel = 12'(m);
        end else begin
          // The falling edge runs down from the high level.
          k_sel     = pt - m;
          den_sel   = 12'(fall_den);
          base_sel  = cfg.high_level;
          minus_sel = ~span[fswg_pkg::SAMPLE_W];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      if (cfg.wave_kind == fswg_pkg::WAVE_SINE) begin
        op_a <= cfg.amplitude;
        op_b <= fswg_pkg::SINE_ROM[pt];
      end else begin
        op_a <= span_mag;
        op_b <= 12'(k_sel);
      end
      den      <= den_sel;
      base     <= base_sel;
      minus    <= minus_sel;
      rect_val <= rect_high ? cfg.high_level : cfg.low_level;
    end
  end

  assign product = fswg_pkg::DIVIDEND_W'(op_a) * fswg_pkg::DIVIDEND_W'(op_b);

  // Only the triangle has a divisor that changes with the point.
  fswg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mul && is_tri),
    .dividend (product),
    .divisor  (den),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_q <= product;
    end
  end

  // Division by 4095: x = q0*4096 + lo = q0*4095 + (q0 + lo), and q0 + lo is at most
  // twice 4095, so two compares finish the quotient.
  assign sine_q0 = prod_q[fswg_pkg::DIVIDEND_W-1:fswg_pkg::SAMPLE_W];
  assign sine_r0 = {1'b0, prod_q[fswg_pkg::SAMPLE_W-1:0]} + {1'b0, sine_q0};
  assign sine_q  = sine_q0
                 + fswg_pkg::SAMPLE_W'(sine_r0 >= {1'b0, fswg_pkg::FULL_SCALE})
                 + fswg_pkg::SAMPLE_W'(sine_r0 >= {fswg_pkg::FULL_SCALE, 1'b0});

  // Division by 127 folds the same way twice; the second remainder stays below 2*127.
  assign saw_q0 = prod_q[fswg_pkg::SAMPLE_W+fswg_pkg::PT_W-1:fswg_pkg::PT_W];
  assign saw_r0 = (fswg_pkg::SAMPLE_W+1)'(prod_q[fswg_pkg::PT_W-1:0]) + {1'b0, saw_q0};
  assign saw_q1 = saw_r0[fswg_pkg::SAMPLE_W:fswg_pkg::PT_W];
  assign saw_r1 = {1'b0, saw_r0[fswg_pkg::PT_W-1:0]} + (fswg_pkg::PT_W+1)'(saw_q1);
  assign saw_q  = saw_q0 + fswg_pkg::SAMPLE_W'(saw_q1)
                + fswg_pkg::SAMPLE_W'(saw_r1 >= {1'b0, fswg_pkg::LAST_POINT});

  assign const_q = (cfg.wave_kind == fswg_pkg::WAVE_SINE) ? sine_q : saw_q;

  always_ff @(posedge clk) begin
    if (cmd.cdiv) begin
      cq <= const_q;
    end
  end

  assign q_sel = is_tri ? quotient[fswg_pkg::SAMPLE_W-1:0] : cq;

  // Every quotient is bounded by the 12-bit span or by full scale.
  assign base_s = $signed({3'b000, base});
  assign q_s    = $signed({3'b000, q_sel});
  assign sum    = minus ? (base_s - q_s) : (base_s + q_s);

  always_comb begin
    if (sum < 0) begin
      shaped = '0;
    end else if (sum > $signed(15'(fswg_pkg::FULL_SCALE))) begin
      shaped = fswg_pkg::FULL_SCALE;
    end else begin
      shaped = sum[fswg_pkg::SAMPLE_W-1:0];
    end
  end

  assign final_sample = (cfg.wave_kind == fswg_pkg::WAVE_RECT) ? rect_val : shaped;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sample      <= final_sample;
      out_point_index <= pt;
      out_cycle_end   <= (pt == fswg_pkg::LAST_POINT);
    end
  end

  assign status.is_rect  = (cfg.wave_kind == fswg_pkg::WAVE_RECT);
  assign status.is_tri   = is_tri;
  assign status.div_done = div_done;
  assign status.out_hold = out_valid && !out_ready;

endmodule

/* src/fswg_ctrl.sv */
// Sequencing state machine for one sample: setup, multiply and divide (skipped for rectangle), write out.
`timescale 1ns / 1ps

module fswg_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fswg_pkg::dp_status_t  status,
  output fswg_pkg::dp_cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_CDIV,
    ST_FIN
  } state_t;

  state_t state;

  assign in_ready     = (state == ST_IDLE);
  assign cmd.accept   = in_ready && in_valid;
  assign cmd.prep     = (state == ST_PREP);
  assign cmd.mul      = (state == ST_MUL);
  assign cmd.cdiv     = (state == ST_CDIV);
  assign cmd.out_load = (state == ST_FIN) && !status.out_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          // Rectangle needs no arithmetic beyond the setup compare.
          state <= status.is_rect ? ST_FIN : ST_MUL;
        end
        ST_MUL: begin
          // Sine and sawtooth divide by a constant in a single step.
          state <= status.is_tri ? ST_DIV : ST_CDIV;
        end
        ST_DIV: begin
          if (status.div_done) begin
            state <= ST_FIN;
          end
        end
        ST_CDIV: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!status.out_hold) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/fswg_checker.sv */
// Port-level checks for the waveform generator, bound to its top level.
`timescale 1ns / 1ps

module fswg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          pready,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [fswg_pkg::PT_W-1:0]     out_point_index,
  input logic                          out_cycle_end
);

  // One tick is in work at a time, so ready drops after every tick beat.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("tick channel stayed ready after a beat");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_cycle_end == (out_point_index == fswg_pkg::LAST_POINT)))
    else $error("cycle_end does not match the last point");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("configuration port inserted wait states");

endmodule

bind four_shape_waveform_sample_generator_core fswg_checker u_fswg_checker (
  .clk             (clk),
  .rst             (rst),
  .pready          (pready),
  .in_valid        (tick.valid),
  .in_ready        (tick.ready),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .out_point_index (result.point_index),
  .out_cycle_end   (result.cycle_end)
);

/* bench/tb.sv */
// Self-checking testbench for the four-shape waveform sample generator core.
`timescale 1ns / 1ps

module tb;
  import fswg_pkg::*;

  localparam int LIMIT       = 400000;
  localparam int LONG_HOLD   = 200;
  localparam int MAX_REPORTS = 200;
  localparam int PHASES      = 16;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic [PT_W-1:0]     point;
    logic                last;
  } dac_point_t;

  class sample_scoreboard;
    dac_point_t          due_points[$];
    wave_kind_t          kind;
    logic [SAMPLE_W-1:0] amp;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [DUTY_W-1:0]   duty;
    logic [PT_W-1:0]     phase;
    int unsigned         failures;

    function new();
      kind     = WAVE_SINE;
      amp      = RST_AMPLITUDE;
      lo       = RST_LOW_LEVEL;
      hi       = RST_HIGH_LEVEL;
      duty     = RST_DUTY;
      phase    = '0;
      failures = 0;
    endfunction

    function int pending();
      return due_points.size();
    endfunction

    function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
      failures++;
      // Keep the log readable when the block is badly broken.
      if (failures <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
    endfunction

    function void write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_WAVE_KIND:    kind = wave_kind_t'(value[1:0]);
        REG_AMPLITUDE:    amp  = value[SAMPLE_W-1:0];
        REG_LOW_LEVEL:    lo   = value[SAMPLE_W-1:0];
        REG_HIGH_LEVEL:   hi   = value[SAMPLE_W-1:0];
        REG_DUTY_PERCENT: duty = value[DUTY_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [DATA_W-1:0] reg_value(logic [2:0] idx);
      case (idx)
        REG_WAVE_KIND:    return DATA_W'(kind);
        REG_AMPLITUDE:    return DATA_W'(amp);
        REG_LOW_LEVEL:    return DATA_W'(lo);
        REG_HIGH_LEVEL:   return DATA_W'(hi);
        default:          return DATA_W'(duty);
      endcase
    endfunction

    function logic [SAMPLE_W-1:0] shape_code(logic [PT_W-1:0] p);
      int lo_i;
      int hi_i;
      int span;
      int ip;
      int rise;
      int m;
      int v;
      lo_i = int'(lo);
      hi_i = int'(hi);
      span = hi_i - lo_i;
      ip   = int'(p);
      rise = (int'(duty) * POINTS) / int'(DUTY_FULL);
      case (kind)
        WAVE_SINE: v = (int'(amp) * int'(SINE_ROM[p])) / int'(FULL_SCALE);
        WAVE_RECT: begin
          if (duty >= DUTY_FULL) v = hi_i;
          else if (duty == 0) v = lo_i;
          else if (duty == DUTY_NEAR_FULL) v = (p == 0) ? lo_i : hi_i;
          else v = (ip < rise) ? hi_i : lo_i;
        end
        WAVE_TRI: begin
          m = rise;
          if (m < 1) m = 1;
          if (m > POINTS - 1) m = POINTS - 1;
          if (ip < m) v = lo_i + (span * ip) / m;
          else v = hi_i - (span * (ip - m)) / (POINTS - m);
        end
        default: v = lo_i + (span * ip) / (POINTS - 1);
      endcase
      if (v < 0) v = 0;
      else if (v > int'(FULL_SCALE)) v = int'(FULL_SCALE);
      return v[SAMPLE_W-1:0];
    endfunction

    function void note_tick(logic restart);
      dac_point_t d;
      logic [PT_W-1:0] p;
      p = restart ? '0 : phase;
      d.sample = shape_code(p);
      d.point  = p;
      d.last   = (p == LAST_POINT);
      due_points.push_back(d);
      phase = p + 1'b1;
    endfunction

    function void check_result(logic [SAMPLE_W-1:0] s, logic [PT_W-1:0] pt, logic ce);
      dac_point_t d;
      if (due_points.size() == 0) begin
        failures++;
        $display("%0t: result beat with nothing due, sample %0d point %0d", $time, s, pt);
        return;
      end
      d = due_points.pop_front();
      if (s !== d.sample) report("sample", 32'(d.sample), 32'(s));
      if (pt !== d.point) report("point_index", 32'(d.point), 32'(pt));
      if (ce !== d.last) report("cycle_end", 32'(d.last), 32'(ce));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  fswg_tick_if   tk ();
  fswg_result_if res ();

  sample_scoreboard sb;
  int unsigned      cycles = 0;
  int               tx_idle_pct = 0;
  int               rx_stall_pct = 0;
  bit               quiet = 1'b0;
  bit               long_hold_due = 1'b0;

  four_shape_waveform_sample_generator_core DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tick    (tk),
    .result  (res)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("four_shape_waveform_sample_generator_core regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && tk.valid && tk.ready) sb.note_tick(tk.restart);
    if (!rst && res.valid && res.ready)
      sb.check_result(res.sample, res.point_index, res.cycle_end);
  end

  // Result side: random stall bursts, one long hold-off on request, none at the end.
  initial begin
    res.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        res.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 99) < rx_stall_pct) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        res.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [2:0] idx, output logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes a register and, for the five defined ones, reads it back; the block must be idle.
  task automatic set_reg(input logic [2:0] idx, input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] got;
    apb_write(idx, data);
    sb.write_reg(idx, data);
    if (idx <= REG_DUTY_PERCENT) begin
      apb_read(idx, got);
      if (got !== sb.reg_value(idx)) sb.report("register readback", sb.reg_value(idx), got);
    end
  endtask

  task automatic offer_tick(input logic restart);
    if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
      tk.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    tk.valid   <= 1'b1;
    tk.restart <= restart;
    @(posedge clk);
    while (!tk.ready) @(posedge clk);
  endtask

  // Stops offering ticks and waits until every due point has come back.
  task automatic settle();
    tk.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_level();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return FULL_SCALE;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [DUTY_W-1:0] pick_duty();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 8'd1;
      2:       return DUTY_NEAR_FULL;
      3:       return DUTY_FULL;
      4:       return 8'hff;
      default: return DUTY_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int n;
    sb = new();
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    tk.valid   = 1'b0;
    tk.restart = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct  = 20;
    rx_stall_pct = 5;

    // Reset defaults: full-scale sine.
    offer_tick(1'b0);
    offer_tick(1'b1);
    offer_tick(1'b0);

    // Rectangle duty corners: full, zero, 99 (point 0 low), one, and beyond 100.
    settle();
    set_reg(REG_WAVE_KIND, {30'($urandom), WAVE_RECT});
    set_reg(REG_DUTY_PERCENT, DATA_W'(DUTY_FULL));
    offer_tick(1'b1);
    settle();
    set_reg(REG_DUTY_PERCENT, '0);
    offer_tick(1'b0);
    settle();
    set_reg(REG_DUTY_PERCENT, DATA_W'(DUTY_NEAR_FULL));
    offer_tick(1'b1);
    offer_tick(1'b0);
    settle();
    set_reg(REG_DUTY_PERCENT, 32'hffff_ff01);
    offer_tick(1'b1);
    offer_tick(1'b0);
    settle();
    set_reg(REG_DUTY_PERCENT, 32'h0000_00ff);
    offer_tick(1'b0);

    // Triangle with the apex clamped at both ends, then with high below low.
    settle();
    set_reg(REG_WAVE_KIND, DATA_W'(WAVE_TRI));
    set_reg(REG_DUTY_PERCENT, '0);
    offer_tick(1'b1);
    offer_tick(1'b0);
    settle();
    set_reg(REG_DUTY_PERCENT, 32'hff);
    offer_tick(1'b0);
    settle();
    set_reg(REG_LOW_LEVEL, DATA_W'(FULL_SCALE));
    set_reg(REG_HIGH_LEVEL, '0);
    set_reg(REG_DUTY_PERCENT, DATA_W'(RST_DUTY));
    offer_tick(1'b1);
    offer_tick(1'b0);

    // Sawtooth running downward, then upward with junk in the upper bits.
    settle();
    set_reg(REG_WAVE_KIND, DATA_W'(WAVE_SAW));
    offer_tick(1'b1);
    offer_tick(1'b0);
    settle();
    set_reg(REG_LOW_LEVEL, 32'hffff_f000);
    set_reg(REG_HIGH_LEVEL, 32'hffff_ffff);
    offer_tick(1'b0);

    // Sine at zero and at a masked mid amplitude; writes past the register list.
    settle();
    set_reg(REG_WAVE_KIND, DATA_W'(WAVE_SINE));
    set_reg(REG_AMPLITUDE, '0);
    offer_tick(1'b0);
    settle();
    set_reg(REG_AMPLITUDE, 32'hffff_f800);
    for (int i = REG_DUTY_PERCENT + 1; i < 8; i++) set_reg(3'(i), $urandom);
    offer_tick(1'b0);

    // Random phases: random register writes each time, mostly free-running points.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if ($urandom_range(0, 3) != 0) set_reg(REG_WAVE_KIND, $urandom);
      if ($urandom_range(0, 3) != 0) set_reg(REG_AMPLITUDE, {20'($urandom), pick_level()});
      if ($urandom_range(0, 3) != 0) set_reg(REG_LOW_LEVEL, {20'($urandom), pick_level()});
      if ($urandom_range(0, 3) != 0) set_reg(REG_HIGH_LEVEL, {20'($urandom), pick_level()});
      if ($urandom_range(0, 3) != 0) set_reg(REG_DUTY_PERCENT, {24'($urandom), pick_duty()});
      if (ph % 5 == 0) set_reg(3'($urandom_range(REG_DUTY_PERCENT + 1, 7)), $urandom);
      case ($urandom_range(0, 2))
        0:       tx_idle_pct = 0;
        1:       tx_idle_pct = 20;
        default: tx_idle_pct = 60;
      endcase
      case ($urandom_range(0, 2))
        0:       rx_stall_pct = 0;
        1:       rx_stall_pct = 3;
        default: rx_stall_pct = 10;
      endcase
      quiet = (ph >= PHASES - 2);
      // Hold the result side off while ticks keep coming, so the input backs up.
      if (ph == 6) begin
        tx_idle_pct   = 0;
        long_hold_due = 1'b1;
      end
      n = $urandom_range(70, 120);
      for (int k = 0; k < n; k++) offer_tick($urandom_range(0, 40) == 0);
    end

    settle();
    repeat (60) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("four_shape_waveform_sample_generator_core regression: pass");
    end else begin
      $display("four_shape_waveform_sample_generator_core regression: fail");
    end
    $finish;
  end

endmodule
